@@ rtl/mhf_pkg.sv @@
// ----------------------------------------------------------------------------
// mhf_pkg
// Shared types, constants and functions of the multicast hash filter:
// reference count width, request and status codes, byte-wise CRC step.
// ----------------------------------------------------------------------------
package mhf_pkg;

  // reference count width and derived values
  localparam int COUNT_WIDTH = 16;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_ONE = count_t'(1);
  localparam count_t COUNT_ZERO = '0;

  // hash table geometry
  localparam int NUM_BINS = 64;
  localparam int BIN_W = 6;
  localparam int NUM_FILTER_BYTES = 8;
  typedef logic [BIN_W-1:0] bin_t;

  // address is taken one byte per cycle
  localparam int MAC_W = 48;
  localparam int MAC_BYTES = 6;
  localparam int BYTE_CNT_W = 3;

  // crc-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // request codes
  localparam logic ACTION_ADD = 1'b0;
  localparam logic ACTION_REMOVE = 1'b1;

  // result status codes
  localparam logic STATUS_ACCEPTED = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // one byte through the reflected crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // bit reversal of a bin number
  function automatic bin_t reverse_bin(input bin_t v);
    bin_t r;
    for (int k = 0; k < BIN_W; k++) begin
      r[BIN_W-1-k] = v[k];
    end
    return r;
  endfunction

endpackage

@@ rtl/mhf_hash.sv @@
// ----------------------------------------------------------------------------
// mhf_hash
// Iterative crc-32 over the six address bytes, one byte per cycle; gives the
// bit-reversed low six crc bits as the hash bin.
// ----------------------------------------------------------------------------
module mhf_hash
  import mhf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAC_W-1:0] mac_address,
  output logic             done,
  output bin_t             hash_index
);

  logic [31:0]           crc;
  logic [MAC_W-1:0]      data;
  logic [BYTE_CNT_W-1:0] bytes_left;
  logic                  running;

  // control: byte counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      bytes_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        bytes_left <= BYTE_CNT_W'(MAC_BYTES);
      end else if (running) begin
        bytes_left <= bytes_left - 1'b1;
        if (bytes_left == BYTE_CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: first byte first
  always_ff @(posedge clk) begin
    if (start) begin
      crc <= CRC_INIT;
      data <= mac_address;
    end else if (running) begin
      crc <= crc_byte(crc, data[7:0]);
      data <= data >> 8;
    end
  end

  assign hash_index = reverse_bin(crc[BIN_W-1:0]);

endmodule

@@ rtl/mhf_count_ram.sv @@
// ----------------------------------------------------------------------------
// mhf_count_ram
// Reference count memory, one read and one write port, registered read.
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module mhf_count_ram
  import mhf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   rd_en,
  input  bin_t   rd_addr,
  output count_t rd_data,
  input  logic   wr_en,
  input  bin_t   wr_addr,
  input  count_t wr_data
);

  count_t              mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  count_t              mem_q;
  logic                valid_q;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = valid_q ? mem_q : COUNT_ZERO;

endmodule

@@ rtl/multicast_hash_filter_refcount_core.sv @@
// ----------------------------------------------------------------------------
// multicast_hash_filter_refcount_core
// Multicast hash filter with per-bin reference counts: hashes a group
// address, updates the bin count in memory and the 64-bit filter register.
// ----------------------------------------------------------------------------
// Flow: a rejected request gives its result straight from the idle state;
// an accepted one goes through six crc byte steps, one count read and one
// update with write-back, which also registers the result. An accepted
// request keeps the core busy until its result is given, so no new request
// is taken before then; rejected requests are taken one per cycle.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset clears the filter and, through valid bits, all counts at once.
// ----------------------------------------------------------------------------
module multicast_hash_filter_refcount_core
  import mhf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             action,
  input  logic [MAC_W-1:0] mac_address,
  output logic             done,
  output logic             status,
  output logic [5:0]       hash_index,
  output logic [2:0]       filter_byte_index,
  output logic [7:0]       filter_byte,
  output logic             filter_changed,
  output logic [15:0]      reference_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_UPDATE
  } state_t;

  state_t state;
  logic   act;
  bin_t   bin;
  logic   accept;
  logic   hash_start;
  logic   hash_done;
  bin_t   hash_bin;
  logic   rd_en;
  count_t cnt_rd;
  count_t cnt_next;
  logic   bit_before;
  logic   bit_after;
  logic [NUM_FILTER_BYTES-1:0][7:0] filter_bytes;
  logic [7:0] byte_before;
  logic [7:0] byte_after;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign hash_start = accept && mac_address[0];
  assign rd_en = (state == S_HASH) && hash_done;

  mhf_hash u_hash (
    .clk         (clk),
    .rst         (rst),
    .start       (hash_start),
    .mac_address (mac_address),
    .done        (hash_done),
    .hash_index  (hash_bin)
  );

  mhf_count_ram u_count_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (hash_bin),
    .rd_data (cnt_rd),
    .wr_en   (state == S_UPDATE),
    .wr_addr (bin),
    .wr_data (cnt_next)
  );

  // count update and filter bit
  always_comb begin
    byte_before = filter_bytes[bin[5:3]];
    bit_before = byte_before[bin[2:0]];
    if (act == ACTION_ADD) begin
      cnt_next = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_ONE;
      bit_after = (cnt_next == COUNT_ONE) ? 1'b1 : bit_before;
    end else begin
      cnt_next = (cnt_rd == COUNT_ZERO) ? cnt_rd : cnt_rd - COUNT_ONE;
      bit_after = (cnt_next == COUNT_ZERO) ? 1'b0 : bit_before;
    end
    byte_after = byte_before;
    byte_after[bin[2:0]] = bit_after;
  end

  // state, filter register and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      filter_bytes <= '0;
      act <= ACTION_ADD;
      bin <= '0;
      status <= STATUS_ACCEPTED;
      hash_index <= '0;
      filter_byte_index <= '0;
      filter_byte <= '0;
      filter_changed <= 1'b0;
      reference_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act <= action;
            if (mac_address[0]) begin
              state <= S_HASH;
            end else begin
              done <= 1'b1;
              status <= STATUS_REJECTED;
              hash_index <= '0;
              filter_byte_index <= '0;
              filter_byte <= '0;
              filter_changed <= 1'b0;
              reference_count <= '0;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bin <= hash_bin;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          filter_bytes[bin[5:3]] <= byte_after;
          done <= 1'b1;
          status <= STATUS_ACCEPTED;
          hash_index <= bin;
          filter_byte_index <= bin[5:3];
          filter_byte <= byte_after;
          filter_changed <= (bit_before != bit_after);
          reference_count <= 16'(cnt_next);
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result is never strobed while a request is in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");

  // hash completion only arrives while waiting for it
  a_hash_state: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH)
    else $error("hash done outside hash wait");

  // rejected requests carry all-zero result fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_REJECTED |->
      reference_count == 16'd0 && filter_byte == 8'd0 && !filter_changed)
    else $error("rejected result not cleared");

  // filter bit changes only on first add or on removal to zero
  a_change_count: assert property (@(posedge clk) disable iff (rst)
    done && filter_changed |->
      (act == ACTION_ADD && reference_count == 16'd1) ||
      (act == ACTION_REMOVE && reference_count == 16'd0))
    else $error("filter change disagrees with count");

  // a changed bit is visible in the reported byte
  a_change_bit: assert property (@(posedge clk) disable iff (rst)
    done && filter_changed |-> filter_byte[hash_index[2:0]] == (act == ACTION_ADD))
    else $error("filter byte does not show the change");

endmodule

@@ sim/multicast_hash_filter_refcount_core_test.sv @@
// ----------------------------------------------------------------------------
// multicast_hash_filter_refcount_core_test
// Self-checking bench for the multicast hash filter core. A directed table
// covers reject codes, extreme addresses, removes below zero and the first
// add and last remove of a bin. Random add/remove traffic, mostly over a small
// pool of group addresses, follows. Typed rows are compared with their table
// result, all others with a local model of the crc hash, bin counts and filter bytes.
// ----------------------------------------------------------------------------
module multicast_hash_filter_refcount_core_test;
  import mhf_pkg::*;

  localparam int RANDOM_REQUESTS = 730;
  localparam int POOL_SIZE = 16;
  localparam longint unsigned CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic        status;
    logic [5:0]  hash_index;
    logic [2:0]  filter_byte_index;
    logic [7:0]  filter_byte;
    logic        filter_changed;
    logic [15:0] reference_count;
  } filter_result_t;

  typedef struct packed {
    logic           action;
    logic [47:0]    mac;
    logic           typed;
    filter_result_t result;
  } request_row_t;

  localparam filter_result_t REJECTED_RESULT =
    '{STATUS_REJECTED, 6'd0, 3'd0, 8'd0, 1'b0, 16'd0};
  localparam filter_result_t UNTYPED = '0;
  localparam int DIRECTED_ROWS = 22;

  // directed requests: typed rows carry their expected result
  localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ACTION_ADD,    48'h0000_0000_0000, 1'b1, REJECTED_RESULT},
    '{ACTION_REMOVE, 48'hFFFF_FFFF_FFFE, 1'b1, REJECTED_RESULT},
    '{ACTION_ADD,    48'hAAAA_AAAA_AAAA, 1'b1, REJECTED_RESULT},
    '{ACTION_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h0000_0000_0001, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h0100_005E_0001, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h0100_0000_3333, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h5555_5555_5555, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h8000_0000_0001, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'hFFFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'h0000_0000_0001, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'h0000_0000_0001, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h7FFF_FFFF_FFFF, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'h0100_005E_0001, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'h7FFF_FFFF_FFFE, 1'b1, REJECTED_RESULT},
    '{ACTION_REMOVE, 48'h0100_0000_3333, 1'b0, UNTYPED},
    '{ACTION_REMOVE, 48'h5555_5555_5555, 1'b0, UNTYPED},
    '{ACTION_ADD,    48'h0100_0000_3333, 1'b0, UNTYPED}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             action = ACTION_ADD;
  logic [MAC_W-1:0] mac_address = '0;
  logic             done;
  logic             status;
  logic [5:0]       hash_index;
  logic [2:0]       filter_byte_index;
  logic [7:0]       filter_byte;
  logic             filter_changed;
  logic [15:0]      reference_count;

  // typed expectation travels with the request it belongs to
  logic             row_typed = 1'b0;
  filter_result_t   row_result = '0;

  count_t           bin_counts [NUM_BINS];
  logic [7:0]       filter_image [NUM_FILTER_BYTES];
  filter_result_t   results_due [$];
  int               mismatch_count = 0;
  longint unsigned  cycle_count = 0;
  int               burst_left = 0;
  logic [47:0]      group_pool [POOL_SIZE];

  multicast_hash_filter_refcount_core uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .mac_address       (mac_address),
    .done              (done),
    .status            (status),
    .hash_index        (hash_index),
    .filter_byte_index (filter_byte_index),
    .filter_byte       (filter_byte),
    .filter_changed    (filter_changed),
    .reference_count   (reference_count)
  );

  always #4 clk = ~clk;

  // bin selected by the reflected crc of the address, bit reversed
  function automatic logic [5:0] address_bin(input logic [47:0] mac);
    logic [31:0] crc;
    logic        feedback;
    logic [5:0]  bin;
    crc = CRC_INIT;
    for (int n = 0; n < MAC_W; n++) begin
      feedback = crc[0] ^ mac[n];
      crc = crc >> 1;
      if (feedback) begin
        crc = crc ^ CRC_POLY;
      end
    end
    for (int k = 0; k < 6; k++) begin
      bin[5-k] = crc[k];
    end
    return bin;
  endfunction

  // apply one request to the local filter image and return its result
  function automatic filter_result_t filter_update(input logic act, input logic [47:0] mac);
    filter_result_t r;
    logic [5:0]     bin;
    logic [2:0]     byte_sel;
    logic [7:0]     bit_mask;
    logic [7:0]     old_byte;
    logic [7:0]     new_byte;
    count_t         cnt;
    r = REJECTED_RESULT;
    if (mac[0]) begin
      bin = address_bin(mac);
      byte_sel = bin[5:3];
      bit_mask = 8'd1 << bin[2:0];
      old_byte = filter_image[byte_sel];
      new_byte = old_byte;
      cnt = bin_counts[bin];
      if (act == ACTION_ADD) begin
        if (cnt != COUNT_MAX) begin
          cnt = cnt + COUNT_ONE;
        end
        if (cnt == COUNT_ONE) begin
          new_byte = old_byte | bit_mask;
        end
      end else begin
        if (cnt != COUNT_ZERO) begin
          cnt = cnt - COUNT_ONE;
        end
        if (cnt == COUNT_ZERO) begin
          new_byte = old_byte & ~bit_mask;
        end
      end
      bin_counts[bin] = cnt;
      filter_image[byte_sel] = new_byte;
      r.status = STATUS_ACCEPTED;
      r.hash_index = bin;
      r.filter_byte_index = byte_sel;
      r.filter_byte = new_byte;
      r.filter_changed = (old_byte != new_byte);
      r.reference_count = 16'(cnt);
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // idle length: mostly short, a few long, none inside a burst
  function automatic int next_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end else if (pick < 45) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 9);
    end
    return $urandom_range(10, 40);
  endfunction

  // one start transfer, held until the core takes it
  task automatic send_request(input logic act, input logic [47:0] mac, input logic typed,
                              input filter_result_t typed_result, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    mac_address <= mac;
    row_typed <= typed;
    row_result <= typed_result;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // result checking and prediction at each accepted transfer
  always @(posedge clk) begin : result_monitor
    filter_result_t seen;
    filter_result_t due;
    filter_result_t predicted;
    if (!rst) begin
      if (done) begin
        seen = '{status, hash_index, filter_byte_index, filter_byte, filter_changed,
                 reference_count};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, actual %0h", $time, seen);
          mismatch_count++;
        end else begin
          due = results_due.pop_front();
          compare_field("status", 16'(due.status), 16'(seen.status));
          compare_field("hash_index", 16'(due.hash_index), 16'(seen.hash_index));
          compare_field("filter_byte_index", 16'(due.filter_byte_index),
                        16'(seen.filter_byte_index));
          compare_field("filter_byte", 16'(due.filter_byte), 16'(seen.filter_byte));
          compare_field("filter_changed", 16'(due.filter_changed),
                        16'(seen.filter_changed));
          compare_field("reference_count", due.reference_count, seen.reference_count);
        end
      end
      if (start && !busy) begin
        predicted = filter_update(action, mac_address);
        results_due.push_back(row_typed ? row_result : predicted);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int              pick;
    logic [47:0]     mac;
    for (int b = 0; b < NUM_BINS; b++) begin
      bin_counts[b] = COUNT_ZERO;
    end
    for (int f = 0; f < NUM_FILTER_BYTES; f++) begin
      filter_image[f] = 8'd0;
    end
    for (int p = 0; p < POOL_SIZE; p++) begin
      group_pool[p] = {16'($urandom), $urandom} | 48'd1;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].action, DIRECTED[i].mac, DIRECTED[i].typed,
                   DIRECTED[i].result, next_gap());
    end

    // random traffic, mostly over a small pool so bins cross zero often
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        mac = group_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 85) begin
        mac = {16'($urandom), $urandom} | 48'd1;
      end else begin
        mac = {16'($urandom), $urandom};
      end
      send_request(1'($urandom_range(0, 1)), mac, 1'b0, UNTYPED, next_gap());
    end
    start <= 1'b0;

    // drain
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ multicast_hash_filter_refcount_core.f @@
rtl/mhf_pkg.sv
rtl/mhf_hash.sv
rtl/mhf_count_ram.sv
rtl/multicast_hash_filter_refcount_core.sv
sim/multicast_hash_filter_refcount_core_test.sv
